// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed in %m");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition in %m");

`else

`define ASSERT_RST(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== src/onaf_pkg.sv =====
// ----------------------------------------------------------------------------
// Outlier neighbor average fix - package
// Frame geometry, field widths, shared types and constants.
// ----------------------------------------------------------------------------
package onaf_pkg;

    localparam int ROWS     = 10;
    localparam int COLS     = 10;
    localparam int SAMPLE_W = 8;
    localparam int ROW_W    = 10;
    localparam int COL_W    = 10;
    localparam int ADDR_W   = $clog2(COLS);
    localparam int SUM_W    = 10;
    localparam int CNT_W    = 3;

    localparam int RECIP3_W     = 10;
    localparam int RECIP3_SHIFT = 11;
    localparam int PROD_W       = SUM_W + RECIP3_W;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [ROW_W-1:0]    row_t;
    typedef logic [COL_W-1:0]    col_t;
    typedef logic [ADDR_W-1:0]   addr_t;

    localparam sample_t              THR_RESET = sample_t'(90);
    localparam logic [RECIP3_W-1:0]  RECIP3    = RECIP3_W'(683);
    localparam row_t                 ROW_LAST  = ROW_W'(ROWS - 1);
    localparam col_t                 COL_LAST  = COL_W'(COLS - 1);

    typedef enum logic {
        PH_STREAM,
        PH_FLUSH
    } phase_t;

    typedef struct packed {
        row_t    row;
        col_t    col;
        logic    has_down;
        sample_t down;
        sample_t orig0;
    } slot_t;

    typedef struct packed {
        logic  valid;
        slot_t slot;
    } issue_t;

endpackage

// ===== src/onaf_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one raw sample per item.
// ----------------------------------------------------------------------------
interface onaf_in_if
    import onaf_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== src/onaf_out_if.sv =====
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one corrected sample and its position.
// ----------------------------------------------------------------------------
interface onaf_out_if
    import onaf_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t sample_out;
    row_t    out_row;
    col_t    out_col;
    logic    frame_last;

    modport source (output valid, output sample_out, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input sample_out, input out_row, input out_col,
                    input frame_last, output ready);
endinterface

// ===== src/outlier_neighbor_average_fix.sv =====
// ----------------------------------------------------------------------------
// Outlier neighbor average fix - top level
// Replaces samples above a threshold by the mean of their in-frame neighbors.
// ----------------------------------------------------------------------------
// Path: once its down neighbor is accepted, a sample passes the s1 slot and
// output registers; last-row samples issue in the flush at the frame's end.
// Throughput: 1 item per cycle while the output is not stalled, set by the
// single read/correct slot; input stalls during each frame's last-row flush.
// Reset: threshold 90, counters at frame start, line buffers left unwritten.
module outlier_neighbor_average_fix
    import onaf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_wr_en,
    input  sample_t cfg_wr_data,
    onaf_in_if.sink samples,
    onaf_out_if.source results
);

    issue_t  issue;
    logic    s1_ready;
    logic    raw_we;
    addr_t   raw_waddr;
    sample_t raw_wdata;
    addr_t   raw_raddr;
    sample_t raw_rdata;
    addr_t   corr_raddr;
    sample_t corr_rdata;
    logic    corr_we;
    addr_t   corr_waddr;
    sample_t corr_wdata;

    onaf_issue u_issue (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .s1_ready   (s1_ready),
        .issue      (issue),
        .raw_we     (raw_we),
        .raw_waddr  (raw_waddr),
        .raw_wdata  (raw_wdata),
        .raw_raddr  (raw_raddr),
        .corr_raddr (corr_raddr)
    );

    onaf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (COLS)
    ) u_raw_ram (
        .clk   (clk),
        .we    (raw_we),
        .waddr (raw_waddr),
        .wdata (raw_wdata),
        .re    (issue.valid),
        .raddr (raw_raddr),
        .rdata (raw_rdata)
    );

    onaf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (COLS)
    ) u_corr_ram (
        .clk   (clk),
        .we    (corr_we),
        .waddr (corr_waddr),
        .wdata (corr_wdata),
        .re    (issue.valid),
        .raddr (corr_raddr),
        .rdata (corr_rdata)
    );

    onaf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .issue       (issue),
        .s1_ready    (s1_ready),
        .raw_rdata   (raw_rdata),
        .corr_rdata  (corr_rdata),
        .corr_we     (corr_we),
        .corr_waddr  (corr_waddr),
        .corr_wdata  (corr_wdata),
        .results     (results)
    );

endmodule

// ===== src/onaf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module onaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/onaf_issue.sv =====
// ----------------------------------------------------------------------------
// Issue stage
// Frame counters, raw line buffer writes, last-row flush sequencer and
// read issue for each sample to correct.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module onaf_issue
    import onaf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    onaf_in_if.sink       samples,
    input  logic          s1_ready,
    output issue_t        issue,
    output logic          raw_we,
    output addr_t         raw_waddr,
    output sample_t       raw_wdata,
    output addr_t         raw_raddr,
    output addr_t         corr_raddr
);

    phase_t  phase_reg;
    phase_t  phase_next;
    row_t    row_reg;
    row_t    row_next;
    col_t    col_reg;
    col_t    col_next;
    col_t    flush_col_reg;
    col_t    flush_col_next;
    sample_t first_reg;

    logic    accept;
    logic    at_end;
    logic    flush_step;
    col_t    cur_col;
    col_t    cur_col_inc;

    assign accept     = samples.valid && samples.ready;
    assign at_end     = (row_reg == ROW_LAST) && (col_reg == COL_LAST);
    assign flush_step = (phase_reg == PH_FLUSH) && s1_ready;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_STREAM:
            begin
                if (accept && at_end)
                begin
                    phase_next = PH_FLUSH;
                end
            end
            PH_FLUSH:
            begin
                if (flush_step && (flush_col_reg == COL_LAST))
                begin
                    phase_next = PH_STREAM;
                end
            end
            default:
            begin
                phase_next = PH_STREAM;
            end
        endcase
    end

    always_comb
    begin
        samples.ready = 1'b0;
        issue         = '0;
        cur_col       = col_reg;
        unique case (phase_reg)
            PH_STREAM:
            begin
                samples.ready       = s1_ready;
                issue.valid         = accept && (row_reg != '0);
                issue.slot.row      = row_reg - ROW_W'(1);
                issue.slot.col      = col_reg;
                issue.slot.has_down = 1'b1;
                issue.slot.down     = samples.sample_in;
                issue.slot.orig0    = first_reg;
                cur_col             = col_reg;
            end
            PH_FLUSH:
            begin
                issue.valid         = s1_ready;
                issue.slot.row      = ROW_LAST;
                issue.slot.col      = flush_col_reg;
                issue.slot.has_down = 1'b0;
                issue.slot.down     = '0;
                issue.slot.orig0    = first_reg;
                cur_col             = flush_col_reg;
            end
            default:
            begin
                samples.ready = 1'b0;
            end
        endcase
    end

    assign cur_col_inc = cur_col + COL_W'(1);
    assign raw_raddr   = cur_col_inc[ADDR_W-1:0];
    assign corr_raddr  = cur_col[ADDR_W-1:0];
    assign raw_we      = accept;
    assign raw_waddr   = col_reg[ADDR_W-1:0];
    assign raw_wdata   = samples.sample_in;

    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        flush_col_next = flush_col_reg;
        if (accept)
        begin
            if (at_end)
            begin
                row_next       = '0;
                col_next       = '0;
                flush_col_next = '0;
            end
            else if (col_reg == COL_LAST)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        if (flush_step)
        begin
            flush_col_next = flush_col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_STREAM;
            row_reg       <= '0;
            col_reg       <= '0;
            flush_col_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            flush_col_reg <= flush_col_next;
        end
    end

    // hold the first raw sample of each row for the column 0 correction
    always_ff @(posedge clk)
    begin
        if (accept && (col_reg == '0))
        begin
            first_reg <= samples.sample_in;
        end
    end

    `ASSERT_RST(a_issue_has_room, clk, rst_n, issue.valid |-> s1_ready)
    `ASSERT_RST(a_flush_starts_new_frame, clk, rst_n,
        ((phase_reg == PH_FLUSH) && $past(phase_reg == PH_STREAM)) |->
        ((row_reg == '0) && (col_reg == '0) && (flush_col_reg == '0)))
    `ASSERT_RST(a_flush_col_bound, clk, rst_n,
        (phase_reg == PH_FLUSH) |-> (flush_col_reg <= COL_LAST))

endmodule

// ===== src/onaf_datapath.sv =====
// ----------------------------------------------------------------------------
// Correction datapath
// Threshold register, neighbor average, corrected row write-back and
// output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module onaf_datapath
    import onaf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  sample_t       cfg_wr_data,
    input  issue_t        issue,
    output logic          s1_ready,
    input  sample_t       raw_rdata,
    input  sample_t       corr_rdata,
    output logic          corr_we,
    output addr_t         corr_waddr,
    output sample_t       corr_wdata,
    onaf_out_if.source    results
);

    sample_t thr_reg;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    slot_t   s1_slot_reg;
    sample_t prev_right_reg;
    sample_t left_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    sample_t out_sample_reg;
    row_t    out_row_reg;
    col_t    out_col_reg;
    logic    out_last_reg;

    logic              out_free;
    logic              s1_move;
    logic              has_up;
    logic              has_left;
    logic              has_right;
    sample_t           orig;
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  cnt;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  quot;
    sample_t           val;

    assign out_free = !out_valid_reg || results.ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s1_ready = !s1_valid_reg || out_free;

    assign has_up    = s1_slot_reg.row != '0;
    assign has_left  = s1_slot_reg.col != '0;
    assign has_right = s1_slot_reg.col != COL_LAST;
    assign orig      = has_left ? prev_right_reg : s1_slot_reg.orig0;

    always_comb
    begin
        sum = SUM_W'(has_up ? corr_rdata : '0)
            + SUM_W'(s1_slot_reg.has_down ? s1_slot_reg.down : '0)
            + SUM_W'(has_left ? left_reg : '0)
            + SUM_W'(has_right ? raw_rdata : '0);
        cnt = CNT_W'(has_up) + CNT_W'(s1_slot_reg.has_down)
            + CNT_W'(has_left) + CNT_W'(has_right);
    end

    assign prod = PROD_W'(sum) * PROD_W'(RECIP3);

    always_comb
    begin
        unique case (cnt)
            CNT_W'(2): quot = sum >> 1;
            CNT_W'(3): quot = SUM_W'(prod >> RECIP3_SHIFT);
            CNT_W'(4): quot = sum >> 2;
            default:   quot = '0;
        endcase
        val = (orig > thr_reg) ? quot[SAMPLE_W-1:0] : orig;
    end

    assign corr_we    = s1_move;
    assign corr_waddr = s1_slot_reg.col[ADDR_W-1:0];
    assign corr_wdata = val;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (issue.valid)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THR_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            s1_slot_reg <= issue.slot;
        end
        if (s1_move)
        begin
            prev_right_reg <= raw_rdata;
            left_reg       <= val;
            out_sample_reg <= val;
            out_row_reg    <= s1_slot_reg.row;
            out_col_reg    <= s1_slot_reg.col;
            out_last_reg   <= (s1_slot_reg.row == ROW_LAST) && (s1_slot_reg.col == COL_LAST);
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.sample_out = out_sample_reg;
    assign results.out_row    = out_row_reg;
    assign results.out_col    = out_col_reg;
    assign results.frame_last = out_last_reg;

    `ASSERT_RST(a_min_two_terms, clk, rst_n, s1_valid_reg |-> (cnt >= CNT_W'(2)))
    `ASSERT_NEVER(a_mean_fits, clk, rst_n,
        s1_valid_reg && (quot[SUM_W-1:SAMPLE_W] != '0))
    `ASSERT_RST(a_s1_holds_on_stall, clk, rst_n,
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_slot_reg)))

endmodule
